// ----- hw/rtl/cru_pkg.sv -----
// Shared constants and types for the camera ray direction unit.
package cru_pkg;

    // Default parameter values
    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 14;

    // Fixed field and format widths
    localparam int PIX_BITS    = 12;
    localparam int SIZE_BITS   = 13;
    localparam int TAN_BITS    = 16;
    localparam int TAN_FRAC    = 12;
    localparam int SCREEN_INT  = 16;
    localparam int VEC_BITS    = 48;
    localparam int COMP_BITS   = 16;
    localparam int NORM_BITS   = 31;
    localparam int SQRT_STEPS  = 32;
    localparam int LEN_BITS    = 64;
    localparam int CFG_IDX_W   = 3;
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 96;

    // Reset values of the registers
    localparam logic [SIZE_BITS-1:0] WIDTH_RST  = 13'd640;
    localparam logic [SIZE_BITS-1:0] HEIGHT_RST = 13'd480;
    localparam logic [TAN_BITS-1:0]  TAN_RST    = 16'd4096;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH   = 3'd0,
        REG_HEIGHT  = 3'd1,
        REG_TAN     = 3'd2,
        REG_FORWARD = 3'd3,
        REG_RIGHT   = 3'd4,
        REG_UP      = 3'd5,
        REG_POS     = 3'd6
    } cfg_reg_t;

endpackage

// ----- hw/rtl/camera_ray_direction_unit.sv -----
// Pinhole camera ray generator: one pixel in, one ray (origin, unit direction) out.
//
//  channel   | dir | handshake           | payload
//  ----------+-----+---------------------+-------------------------------------------
//  s_        | in  | s_tvalid/s_tready   | s_tdata: pixel_x, pixel_y
//  m_        | out | m_tvalid/m_tready   | m_tdata: origin_x/y/z, dir_x/y/z
//  cfg_      | in  | cfg_valid/cfg_ready | cfg_index, cfg_data (register write)
//
// One item per cycle sustained while the skid stage is empty. The pipeline holds
// QS screen divide steps, NS leading-one search steps, 32 square root steps
// and QD normalizing divide steps, one per register stage.
// rst_n clears all valid bits and loads the register reset values; payload
// registers are not reset. The whole pipeline advances together; a two-entry
// output (register plus skid) absorbs one stalled item, so s_tready depends
// on a register only and a stall drops or repeats nothing.
module camera_ray_direction_unit #(
    parameter int COORD_BITS = cru_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = cru_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // pixel items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [cru_pkg::IN_DATA_W-1:0]       s_tdata,  // pixel_x[11:0], pixel_y[23:12]
    // ray items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cru_pkg::OUT_DATA_W-1:0]      m_tdata,  // origin_x, origin_y, origin_z,
                                                          // dir_x, dir_y, dir_z (16 each)
    // register writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cru_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cru_pkg::VEC_BITS-1:0]        cfg_data
);
    import cru_pkg::*;

    // Widths
    localparam int CW     = (COORD_BITS < PIX_BITS) ? COORD_BITS : PIX_BITS;
    localparam int MAG_W  = (CW + 1 > SIZE_BITS) ? CW + 1 : SIZE_BITS;
    localparam int NUM_W  = MAG_W + 1;
    localparam int AW     = MAG_W + TAN_BITS;
    localparam int DEN_W  = SIZE_BITS + TAN_FRAC;
    localparam int QS     = FRAC_BITS + SCREEN_INT;
    localparam int RW     = FRAC_BITS + 42;
    localparam int SXW    = QS + 1;
    localparam int PW     = COMP_BITS + SXW;
    localparam int DW     = PW + 2;
    localparam int NS     = $clog2(DW);
    localparam int BLW    = $clog2(DW + 1);
    localparam int SQ_W   = 2 * NORM_BITS;
    localparam int SW     = SQRT_STEPS;
    localparam int QD     = FRAC_BITS + 1;
    localparam int DVW    = FRAC_BITS + 33;
    localparam int NST    = 12 + QS + NS + SQRT_STEPS + QD;

    typedef logic [2:0][NORM_BITS-1:0] cvec_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SIZE_BITS-1:0] width_reg, height_reg;
    logic [TAN_BITS-1:0]  tan_reg;
    logic [VEC_BITS-1:0]  fwd_reg, right_reg, up_reg, pos_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
            tan_reg    <= TAN_RST;
            fwd_reg    <= '0;
            right_reg  <= '0;
            up_reg     <= '0;
            pos_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_WIDTH:   width_reg  <= cfg_data[SIZE_BITS-1:0];
                REG_HEIGHT:  height_reg <= cfg_data[SIZE_BITS-1:0];
                REG_TAN:     tan_reg    <= cfg_data[TAN_BITS-1:0];
                REG_FORWARD: fwd_reg    <= cfg_data;
                REG_RIGHT:   right_reg  <= cfg_data;
                REG_UP:      up_reg     <= cfg_data;
                REG_POS:     pos_reg    <= cfg_data;
                default:     ;
            endcase
        end
    end

    // zero height acts as one
    logic [SIZE_BITS-1:0] h_eff;
    logic [DEN_W-1:0]     den_s;
    assign h_eff = (height_reg == '0) ? SIZE_BITS'(1) : height_reg;
    assign den_s = {h_eff, {TAN_FRAC{1'b0}}};

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic                  en;
    logic [NST-1:0]        vld_reg;
    logic                  deliver;
    logic                  out_valid_reg, skid_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg, skid_data_reg;
    logic [OUT_DATA_W-1:0] new_item;

    // advance whenever the skid stage is free
    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign deliver  = en && vld_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], s_tvalid};
    end

    // ------------------------------------------------------------------
    // Stage 1: signed screen numerators and their magnitudes
    // ------------------------------------------------------------------
    logic [CW-1:0]           px, py;
    logic signed [NUM_W-1:0] nx_c, ny_c;
    logic [MAG_W-1:0]        s1_magx_reg, s1_magy_reg;
    logic                    s1_negx_reg, s1_negy_reg;

    assign px   = s_tdata[CW-1:0];
    assign py   = s_tdata[PIX_BITS+CW-1:PIX_BITS];
    assign nx_c = $signed(NUM_W'({px, 1'b1})) - $signed(NUM_W'(width_reg));
    assign ny_c = $signed(NUM_W'(h_eff)) - $signed(NUM_W'({py, 1'b1}));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_negx_reg <= nx_c[NUM_W-1];
            s1_negy_reg <= ny_c[NUM_W-1];
            s1_magx_reg <= nx_c[NUM_W-1] ? MAG_W'(-nx_c) : MAG_W'(nx_c);
            s1_magy_reg <= ny_c[NUM_W-1] ? MAG_W'(-ny_c) : MAG_W'(ny_c);
        end
    end

    // Stage 2: scale by the tangent
    logic [AW-1:0] s2_ax_reg, s2_ay_reg;
    logic          s2_negx_reg, s2_negy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_ax_reg   <= AW'(s1_magx_reg) * AW'(tan_reg);
            s2_ay_reg   <= AW'(s1_magy_reg) * AW'(tan_reg);
            s2_negx_reg <= s1_negx_reg;
            s2_negy_reg <= s1_negy_reg;
        end
    end

    // Stage 3: dividend with rounding term, overflow check against the limit
    logic [RW-1:0] sdx_rem_reg [0:QS];
    logic [RW-1:0] sdy_rem_reg [0:QS];
    logic [QS-1:0] sdx_q_reg   [0:QS];
    logic [QS-1:0] sdy_q_reg   [0:QS];
    logic [3:0]    sd_flag_reg [0:QS];   // negx, negy, ovfx, ovfy
    logic [RW-1:0] nxs_c, nys_c, dlim_c;

    assign nxs_c  = (RW'(s2_ax_reg) << FRAC_BITS) + (RW'(h_eff) << (TAN_FRAC - 1));
    assign nys_c  = (RW'(s2_ay_reg) << FRAC_BITS) + (RW'(h_eff) << (TAN_FRAC - 1));
    assign dlim_c = RW'(den_s) << QS;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sdx_rem_reg[0] <= nxs_c;
            sdy_rem_reg[0] <= nys_c;
            sdx_q_reg[0]   <= '0;
            sdy_q_reg[0]   <= '0;
            sd_flag_reg[0] <= {nys_c >= dlim_c, nxs_c >= dlim_c, s2_negy_reg, s2_negx_reg};
        end
    end

    // Screen divide: one quotient bit per stage, top bit first
    for (genvar j = 0; j < QS; j++)
    begin : g_sdiv
        localparam int K = QS - 1 - j;
        logic [RW-1:0] dsh;
        assign dsh = RW'(den_s) << K;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sd_flag_reg[j+1] <= sd_flag_reg[j];
                if (sdx_rem_reg[j] >= dsh)
                begin
                    sdx_rem_reg[j+1] <= sdx_rem_reg[j] - dsh;
                    sdx_q_reg[j+1]   <= sdx_q_reg[j] | (QS'(1) << K);
                end
                else
                begin
                    sdx_rem_reg[j+1] <= sdx_rem_reg[j];
                    sdx_q_reg[j+1]   <= sdx_q_reg[j];
                end
                if (sdy_rem_reg[j] >= dsh)
                begin
                    sdy_rem_reg[j+1] <= sdy_rem_reg[j] - dsh;
                    sdy_q_reg[j+1]   <= sdy_q_reg[j] | (QS'(1) << K);
                end
                else
                begin
                    sdy_rem_reg[j+1] <= sdy_rem_reg[j];
                    sdy_q_reg[j+1]   <= sdy_q_reg[j];
                end
            end
        end
    end

    // Saturate and apply sign
    logic [QS-1:0]         qx_c, qy_c;
    logic signed [SXW-1:0] sx_reg, sy_reg;

    assign qx_c = sd_flag_reg[QS][2] ? {QS{1'b1}} : sdx_q_reg[QS];
    assign qy_c = sd_flag_reg[QS][3] ? {QS{1'b1}} : sdy_q_reg[QS];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg <= sd_flag_reg[QS][0] ? -$signed(SXW'(qx_c)) : $signed(SXW'(qx_c));
            sy_reg <= sd_flag_reg[QS][1] ? -$signed(SXW'(qy_c)) : $signed(SXW'(qy_c));
        end
    end

    // ------------------------------------------------------------------
    // Basis combination
    // ------------------------------------------------------------------
    function automatic logic signed [COMP_BITS-1:0] comp(input logic [VEC_BITS-1:0] v,
                                                         input int idx);
        comp = $signed(v[COMP_BITS*idx +: COMP_BITS]);
    endfunction

    logic signed [PW-1:0] pr_reg [0:2];
    logic signed [PW-1:0] pu_reg [0:2];
    logic signed [DW-1:0] d_reg  [0:2];
    logic [2:0]           dneg_c;
    logic [DW-1:0]        m_c    [0:2];

    for (genvar i = 0; i < 3; i++)
    begin : g_comb
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                pr_reg[i] <= PW'(comp(right_reg, i)) * PW'(sx_reg);
                pu_reg[i] <= PW'(comp(up_reg, i)) * PW'(sy_reg);
                d_reg[i]  <= (DW'(comp(fwd_reg, i)) <<< FRAC_BITS)
                           + DW'(pr_reg[i]) + DW'(pu_reg[i]);
            end
        end
        assign dneg_c[i] = d_reg[i][DW-1];
        assign m_c[i]    = d_reg[i][DW-1] ? DW'(-d_reg[i]) : DW'(d_reg[i]);
    end

    // Magnitude stage
    logic [DW-1:0] mg_reg [0:2];
    logic [2:0]    mgneg_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mg_reg[0] <= m_c[0];
            mg_reg[1] <= m_c[1];
            mg_reg[2] <= m_c[2];
            mgneg_reg <= dneg_c;
        end
    end

    // Largest magnitude, then a pipelined leading-one search
    logic [DW-1:0]  mx01_c, mx_c;
    logic [DW-1:0]  sv_reg  [0:NS];
    logic [BLW-1:0] sn_reg  [0:NS];
    logic [DW-1:0]  sm_reg  [0:NS][0:2];
    logic [3:0]     sf_reg  [0:NS];      // neg x,y,z, zero

    assign mx01_c = (mg_reg[1] > mg_reg[0]) ? mg_reg[1] : mg_reg[0];
    assign mx_c   = (mg_reg[2] > mx01_c) ? mg_reg[2] : mx01_c;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sv_reg[0]    <= mx_c;
            sn_reg[0]    <= '0;
            sm_reg[0][0] <= mg_reg[0];
            sm_reg[0][1] <= mg_reg[1];
            sm_reg[0][2] <= mg_reg[2];
            sf_reg[0]    <= {mx_c == '0, mgneg_reg};
        end
    end

    for (genvar j = 0; j < NS; j++)
    begin : g_lead
        localparam int SH = 1 << (NS - 1 - j);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sm_reg[j+1] <= sm_reg[j];
                sf_reg[j+1] <= sf_reg[j];
                if ((sv_reg[j] >> SH) != '0)
                begin
                    sv_reg[j+1] <= sv_reg[j] >> SH;
                    sn_reg[j+1] <= sn_reg[j] + BLW'(SH);
                end
                else
                begin
                    sv_reg[j+1] <= sv_reg[j];
                    sn_reg[j+1] <= sn_reg[j];
                end
            end
        end
    end

    // Bring the largest component to NORM_BITS bits, same shift for all
    logic [BLW-1:0] bl_c;
    cvec_t          cm_c;
    cvec_t          cm_reg;
    logic [3:0]     cf_reg;

    assign bl_c = sn_reg[NS] + BLW'(sv_reg[NS] != '0);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (bl_c > BLW'(NORM_BITS))
                cm_c[i] = NORM_BITS'(sm_reg[NS][i] >> (bl_c - BLW'(NORM_BITS)));
            else
                cm_c[i] = NORM_BITS'(sm_reg[NS][i] << (BLW'(NORM_BITS) - bl_c));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cm_reg <= cm_c;
            cf_reg <= sf_reg[NS];
        end
    end

    // Squares, then their sum
    logic [SQ_W-1:0]     sq_reg [0:2];
    cvec_t               qm_reg;
    logic [3:0]          qf_reg;
    logic [LEN_BITS-1:0] len_reg;
    cvec_t               lm_reg;
    logic [3:0]          lf_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= SQ_W'(cm_reg[i]) * SQ_W'(cm_reg[i]);
            qm_reg  <= cm_reg;
            qf_reg  <= cf_reg;
            len_reg <= LEN_BITS'(sq_reg[0]) + LEN_BITS'(sq_reg[1]) + LEN_BITS'(sq_reg[2]);
            lm_reg  <= qm_reg;
            lf_reg  <= qf_reg;
        end
    end

    // Digit-by-digit square root, one result bit per stage
    logic [LEN_BITS-1:0] rv_reg  [0:SW];
    logic [LEN_BITS-1:0] rr_reg  [0:SW];
    cvec_t               rm_reg  [0:SW];
    logic [3:0]          rf_reg  [0:SW];

    assign rv_reg[0] = len_reg;
    assign rr_reg[0] = '0;
    assign rm_reg[0] = lm_reg;
    assign rf_reg[0] = lf_reg;

    for (genvar j = 0; j < SW; j++)
    begin : g_sqrt
        localparam logic [LEN_BITS-1:0] BIT = LEN_BITS'(1) << (LEN_BITS - 2 - 2 * j);
        logic [LEN_BITS-1:0] trial;
        assign trial = rr_reg[j] + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rm_reg[j+1] <= rm_reg[j];
                rf_reg[j+1] <= rf_reg[j];
                if (rv_reg[j] >= trial)
                begin
                    rv_reg[j+1] <= rv_reg[j] - trial;
                    rr_reg[j+1] <= (rr_reg[j] >> 1) + BIT;
                end
                else
                begin
                    rv_reg[j+1] <= rv_reg[j];
                    rr_reg[j+1] <= rr_reg[j] >> 1;
                end
            end
        end
    end

    // Normalizing divide: q = (c * 2^FRAC + s/2) / s, one bit per stage
    logic [SW-1:0]  s_c;
    logic [DVW-1:0] nr_reg [0:QD][0:2];
    logic [QD-1:0]  nq_reg [0:QD][0:2];
    logic [SW-1:0]  ns_reg [0:QD];
    logic [3:0]     nf_reg [0:QD];

    assign s_c = rr_reg[SW][SW-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                nr_reg[0][i] <= (DVW'(rm_reg[SW][i]) << FRAC_BITS) + DVW'(s_c >> 1);
                nq_reg[0][i] <= '0;
            end
            ns_reg[0] <= s_c;
            nf_reg[0] <= rf_reg[SW];
        end
    end

    for (genvar j = 0; j < QD; j++)
    begin : g_ndiv
        localparam int K = QD - 1 - j;
        logic [DVW-1:0] ssh;
        assign ssh = DVW'(ns_reg[j]) << K;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ns_reg[j+1] <= ns_reg[j];
                nf_reg[j+1] <= nf_reg[j];
                for (int i = 0; i < 3; i++)
                begin
                    if (nr_reg[j][i] >= ssh)
                    begin
                        nr_reg[j+1][i] <= nr_reg[j][i] - ssh;
                        nq_reg[j+1][i] <= nq_reg[j][i] | (QD'(1) << K);
                    end
                    else
                    begin
                        nr_reg[j+1][i] <= nr_reg[j][i];
                        nq_reg[j+1][i] <= nq_reg[j][i];
                    end
                end
            end
        end
    end

    // Sign, saturate, pack with the origin
    logic [2:0][COMP_BITS-1:0] dir_c;

    always_comb
    begin
        logic [16:0]        v;
        logic signed [17:0] sr;
        for (int i = 0; i < 3; i++)
        begin
            v  = (32'(nq_reg[QD][i]) > 32'd65535) ? 17'd65535 : 17'(nq_reg[QD][i]);
            sr = nf_reg[QD][i] ? -$signed({1'b0, v}) : $signed({1'b0, v});
            if (nf_reg[QD][3])
                dir_c[i] = '0;
            else if (sr > 18'sd32767)
                dir_c[i] = 16'h7fff;
            else if (sr < -18'sd32768)
                dir_c[i] = 16'h8000;
            else
                dir_c[i] = sr[COMP_BITS-1:0];
        end
    end

    assign new_item = {dir_c, pos_reg};

    // ------------------------------------------------------------------
    // Output register and skid stage
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg  <= skid_valid_reg || deliver;
            skid_valid_reg <= 1'b0;
        end
        else if (deliver)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
            out_data_reg <= skid_valid_reg ? skid_data_reg : new_item;
        else if (deliver)
            skid_data_reg <= new_item;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    localparam int SETUP_IDX = 11 + QS + NS + SQRT_STEPS;

    // the skid stage only holds an item behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while output is empty");

    // the skid stage fills only when the output stalled
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid filled without an output stall");

    // a finished item always lands in the output or the skid stage
    a_deliver_lands: assert property (@(posedge clk) disable iff (!rst_n)
        deliver |=> (out_valid_reg || skid_valid_reg))
        else $error("finished item lost");

    // the length of a normalized nonzero direction is at least 2^30
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[SETUP_IDX] && !nf_reg[0][3]) |-> (ns_reg[0][SW-1:SW-2] != 2'b00))
        else $error("normalized length out of range");
`endif

endmodule

// ----- bench/cru_checker.sv -----
// Ray checker: watches the pixel, ray and register channels, predicts rays and compares.
`timescale 1ns / 1ps

module cru_checker
    import cru_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [VEC_BITS-1:0]   cfg_data,
    output int                    errors,
    output int                    pending
);

    typedef struct packed {
        logic [COMP_BITS-1:0] dir_z;
        logic [COMP_BITS-1:0] dir_y;
        logic [COMP_BITS-1:0] dir_x;
        logic [COMP_BITS-1:0] origin_z;
        logic [COMP_BITS-1:0] origin_y;
        logic [COMP_BITS-1:0] origin_x;
    } ray_t;

    logic [SIZE_BITS-1:0] img_w, img_h;
    logic [TAN_BITS-1:0]  tan_fov;
    logic [VEC_BITS-1:0]  fwd_vec, right_vec, up_vec, cam_pos;

    ray_t expected_rays[$];
    int   ray_count;

    function automatic longint signed half_of(logic [VEC_BITS-1:0] v, int idx);
        logic signed [COMP_BITS-1:0] c;
        c = v[COMP_BITS*idx +: COMP_BITS];
        return longint'(c);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, bval;
        res  = 0;
        bval = 64'd1 << 62;
        for (int i = 0; i < SQRT_STEPS; i++)
        begin
            if (v >= res + bval)
            begin
                v   = v - (res + bval);
                res = (res >> 1) + bval;
            end
            else
                res = res >> 1;
            bval = bval >> 2;
        end
        return res;
    endfunction

    // Screen coordinate: round half away from zero, saturate the magnitude.
    function automatic longint signed screen_coord(longint signed num, longint unsigned h);
        longint unsigned lim, den, mag, q;
        lim = (64'd1 << (FRAC_BITS_DEF + SCREEN_INT)) - 1;
        den = h << TAN_FRAC;
        mag = (((num < 0) ? -num : num) * longint'(tan_fov)) << FRAC_BITS_DEF;
        q   = (mag + den / 2) / den;
        if (q > lim)
            q = lim;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic ray_t trace_ray(logic [PIX_BITS-1:0] px, logic [PIX_BITS-1:0] py);
        ray_t            r;
        longint signed   sx, sy, v;
        longint signed   d[3];
        longint unsigned m[3];
        longint unsigned h, maxm, len2, s, q;
        int              bl;
        h    = (img_h == 0) ? 1 : img_h;
        sx   = screen_coord(2 * longint'(px) + 1 - longint'(img_w), h);
        sy   = screen_coord(longint'(h) - 2 * longint'(py) - 1, h);
        maxm = 0;
        len2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            d[i] = half_of(fwd_vec, i) * (64'sd1 <<< FRAC_BITS_DEF)
                 + half_of(right_vec, i) * sx + half_of(up_vec, i) * sy;
            m[i] = (d[i] < 0) ? -d[i] : d[i];
            if (m[i] > maxm)
                maxm = m[i];
        end
        r.origin_x = cam_pos[15:0];
        r.origin_y = cam_pos[31:16];
        r.origin_z = cam_pos[47:32];
        if (maxm == 0)
        begin
            r.dir_x = '0;
            r.dir_y = '0;
            r.dir_z = '0;
            return r;
        end
        bl = 0;
        while (bl < 64 && (maxm >> bl) != 0)
            bl++;
        for (int i = 0; i < 3; i++)
        begin
            if (bl > NORM_BITS)
                m[i] = m[i] >> (bl - NORM_BITS);
            else
                m[i] = m[i] << (NORM_BITS - bl);
            len2 += m[i] * m[i];
        end
        s = int_sqrt(len2);
        for (int i = 0; i < 3; i++)
        begin
            q = ((m[i] << FRAC_BITS_DEF) + s / 2) / s;
            v = (q > 65535) ? 65535 : longint'(q);
            if (d[i] < 0)
                v = -v;
            if (v > 32767)
                v = 32767;
            if (v < -32768)
                v = -32768;
            case (i)
                0: r.dir_x = v[15:0];
                1: r.dir_y = v[15:0];
                default: r.dir_z = v[15:0];
            endcase
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("ray %0d: %s is %h, predicted %h", ray_count, what, got, want);
        errors++;
    endtask

    assign pending = expected_rays.size();

    initial errors = 0;

    always @(posedge clk or negedge rst_n)
    begin
        ray_t got, want;
        if (!rst_n)
        begin
            img_w     <= WIDTH_RST;
            img_h     <= HEIGHT_RST;
            tan_fov   <= TAN_RST;
            fwd_vec   <= '0;
            right_vec <= '0;
            up_vec    <= '0;
            cam_pos   <= '0;
            expected_rays.delete();
            ray_count = 0;
        end
        else
        begin
            // Predict with the settings in force before any write at this edge.
            if (s_tvalid && s_tready)
                expected_rays.push_back(trace_ray(s_tdata[11:0], s_tdata[23:12]));
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (expected_rays.size() == 0)
                begin
                    $display("ray %0d: result with no pixel waiting", ray_count);
                    errors++;
                end
                else
                begin
                    want = expected_rays.pop_front();
                    if (got.origin_x != want.origin_x)
                        report_mismatch("origin_x", got.origin_x, want.origin_x);
                    if (got.origin_y != want.origin_y)
                        report_mismatch("origin_y", got.origin_y, want.origin_y);
                    if (got.origin_z != want.origin_z)
                        report_mismatch("origin_z", got.origin_z, want.origin_z);
                    if (got.dir_x != want.dir_x)
                        report_mismatch("dir_x", got.dir_x, want.dir_x);
                    if (got.dir_y != want.dir_y)
                        report_mismatch("dir_y", got.dir_y, want.dir_y);
                    if (got.dir_z != want.dir_z)
                        report_mismatch("dir_z", got.dir_z, want.dir_z);
                end
                ray_count++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_WIDTH:   img_w     <= cfg_data[SIZE_BITS-1:0];
                    REG_HEIGHT:  img_h     <= cfg_data[SIZE_BITS-1:0];
                    REG_TAN:     tan_fov   <= cfg_data[TAN_BITS-1:0];
                    REG_FORWARD: fwd_vec   <= cfg_data;
                    REG_RIGHT:   right_vec <= cfg_data;
                    REG_UP:      up_vec    <= cfg_data;
                    REG_POS:     cam_pos   <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

endmodule

// ----- bench/testbench.sv -----
// Top of the ray unit bench: clock, reset, pixel and register stimulus, verdict.
`timescale 1ns / 1ps

module testbench;
    import cru_pkg::*;

    // Index past the register list; the block must drop writes to it.
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
    localparam logic [15:0] ONE_Q14 = 16'sd16384;
    localparam logic [15:0] NEG_ONE_Q14 = -16'sd16384;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_PIXELS  = 70;
    localparam int HOLD_PIXELS   = 140;   // more than the pipeline holds
    localparam int HOLD_PHASE    = 2;
    localparam int LONG_HOLD     = 400;
    localparam int TAIL_CYCLES   = 150;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // pixel_x[11:0], pixel_y[23:12]
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [VEC_BITS-1:0]   cfg_data;

    int   errors;
    int   pending;
    logic pixel_taken, reg_taken;
    logic hold_request;   // asks the receiver for one long stall
    logic use_gaps;
    int   burst_left;

    camera_ray_direction_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cru_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Latch each handshake at the edge so the stimulus can look at it at the falling edge.
    always @(posedge clk)
    begin
        pixel_taken <= s_tvalid && s_tready;
        reg_taken   <= cfg_valid && cfg_ready;
    end

    function automatic logic [VEC_BITS-1:0] pack3(logic [15:0] x, logic [15:0] y,
                                                  logic [15:0] z);
        return {z, y, x};
    endfunction

    function automatic logic [VEC_BITS-1:0] rand48();
        return VEC_BITS'({$urandom(), $urandom()});
    endfunction

    // Write one register; call only while no ray is in flight.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VEC_BITS-1:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(negedge clk);
        while (!reg_taken);
        cfg_valid = 1'b0;
    endtask

    task automatic set_camera(logic [12:0] w, logic [12:0] h, logic [15:0] tan_v,
                              logic [VEC_BITS-1:0] f, logic [VEC_BITS-1:0] r,
                              logic [VEC_BITS-1:0] u, logic [VEC_BITS-1:0] p);
        write_reg(REG_WIDTH, VEC_BITS'(w));
        write_reg(REG_HEIGHT, VEC_BITS'(h));
        write_reg(REG_TAN, VEC_BITS'(tan_v));
        write_reg(REG_FORWARD, f);
        write_reg(REG_RIGHT, r);
        write_reg(REG_UP, u);
        write_reg(REG_POS, p);
    endtask

    // Offer one pixel; keep valid high into the next item when bursting.
    task automatic send_pixel(logic [PIX_BITS-1:0] px, logic [PIX_BITS-1:0] py);
        if (use_gaps && burst_left == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6))
                @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid = 1'b1;
        s_tdata  = {py, px};
        do
            @(negedge clk);
        while (!pixel_taken);
        if (burst_left > 0)
            burst_left--;
    endtask

    // Drop valid and hold until every predicted ray has come out.
    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Receiver: ready follows a pattern that is redrawn at random from four; one long stall on request.
    initial
    begin
        int mode;
        m_tready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            for (int i = 0; i < 100; i++)
            begin
                @(negedge clk);
                if (hold_request)
                begin
                    m_tready = 1'b0;
                    for (int k = 0; k < LONG_HOLD; k++)
                        @(negedge clk);
                    hold_request = 1'b0;
                end
                case (mode)
                    0: m_tready = 1'b1;
                    1: m_tready = $urandom_range(0, 1);
                    2: m_tready = ($urandom_range(0, 7) != 0);
                    default: m_tready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Run limit, far above the slowest passing run.
    initial
    begin
        #5_000_000;
        $display("camera_ray_direction_unit: mismatch");
        $finish;
    end

    initial
    begin
        logic [VEC_BITS-1:0] f, r, u;
        int                  count;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_WIDTH;
        cfg_data     = '0;
        hold_request = 1'b0;
        use_gaps     = 1'b0;
        burst_left   = 0;
        rst_n        = 1'b0;
        repeat (11)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Settings after reset: all vectors zero, so every direction is degenerate.
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd320, 12'd240);
        drain();

        // Plain camera looking down -z; the bogus index must leave the registers alone.
        set_camera(13'd640, 13'd480, 16'd4096, pack3(16'd0, 16'd0, NEG_ONE_Q14),
                   pack3(ONE_Q14, 16'd0, 16'd0), pack3(16'd0, ONE_Q14, 16'd0),
                   pack3(16'sd100, -16'sd200, 16'sd300));
        write_reg(REG_NONE, rand48());
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd639, 12'd479);
        send_pixel(12'd320, 12'd240);
        send_pixel(12'd319, 12'd239);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'haaa, 12'h555);
        send_pixel(12'h555, 12'haaa);
        drain();

        // Zero width and zero height, widest tangent, extreme vector components.
        set_camera(13'd0, 13'd0, 16'hffff, pack3(16'h8000, 16'h7fff, 16'h8000),
                   pack3(16'h7fff, 16'h8000, 16'h7fff), pack3(16'h8000, 16'h8000, 16'h7fff),
                   pack3(16'h8000, 16'h7fff, 16'hffff));
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd2048, 12'd0);
        drain();

        // Largest image with zero tangent: the ray is the forward vector alone.
        set_camera(13'd4096, 13'd4096, 16'd0, pack3(16'sd1234, -16'sd5678, 16'sd42),
                   rand48(), rand48(), rand48());
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd17, 12'd3000);
        drain();

        // Odd width over a one-row image: the vertical screen coordinate saturates for the far row.
        set_camera(13'd4095, 13'd1, 16'hffff, pack3(16'd0, 16'd0, ONE_Q14),
                   pack3(ONE_Q14, 16'd0, 16'd0), pack3(16'd0, NEG_ONE_Q14, 16'd0),
                   rand48());
        send_pixel(12'd0, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd2047, 12'd0);
        drain();

        // Random phases: new camera each time, then a stream of pixels.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph % 3 == 0)
            begin
                // Near-realistic camera with random signs and small skew.
                f = pack3(16'($urandom_range(0, 2000)), 16'($urandom_range(0, 2000)),
                          $urandom_range(0, 1) ? ONE_Q14 : NEG_ONE_Q14);
                r = pack3($urandom_range(0, 1) ? ONE_Q14 : NEG_ONE_Q14, 16'd0,
                          16'($urandom_range(0, 2000)));
                u = pack3(16'd0, $urandom_range(0, 1) ? ONE_Q14 : NEG_ONE_Q14,
                          16'($urandom_range(0, 2000)));
                set_camera(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
                           16'($urandom_range(1024, 12000)), f, r, u, rand48());
            end
            else
                set_camera(13'($urandom()), 13'($urandom()), 16'($urandom()), rand48(),
                           rand48(), rand48(), rand48());
            use_gaps   = (ph % 2 == 1);
            burst_left = 0;
            count      = PHASE_PIXELS;
            // offer enough items during the long stall to fill the pipeline
            if (ph == HOLD_PHASE)
            begin
                hold_request = 1'b1;
                count        = HOLD_PIXELS;
            end
            for (int n = 0; n < count; n++)
                send_pixel(12'($urandom()), 12'($urandom()));
            drain();
        end

        repeat (TAIL_CYCLES)
            @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("camera_ray_direction_unit: match");
        else
            $display("camera_ray_direction_unit: mismatch");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/cru_pkg.sv
hw/rtl/camera_ray_direction_unit.sv
bench/cru_checker.sv
bench/testbench.sv
